FILE: src/fda_pkg.sv
package fda_pkg;

    // Frame store geometry
    localparam int FRAME_DEPTH = 524288;
    localparam int ADDR_W      = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int FPIX_W      = 20;
    localparam int CNT_W       = (ADDR_W + 1 > FPIX_W) ? ADDR_W + 1 : FPIX_W;

    // Pixel and result widths
    localparam int CH_W   = 8;
    localparam int GAIN_W = 8;
    localparam int SUM_W  = 12;
    localparam int PROD_W = 25;

    // Gray conversion: (b + 6g + 3r + 5) / 10 as multiply by 6554 and shift by 16
    localparam logic [SUM_W-1:0]  W_GREEN    = 12'd6;
    localparam logic [SUM_W-1:0]  W_RED      = 12'd3;
    localparam logic [SUM_W-1:0]  ROUND_BIAS = 12'd5;
    localparam logic [PROD_W-1:0] RECIP_10   = 25'd6554;
    localparam int                GRAY_SHIFT = 16;

    localparam logic [CH_W-1:0] SAT_MAX = 8'd255;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = FPIX_W;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS = 1'd1;

    localparam logic [GAIN_W-1:0] GAIN_RESET         = 8'd5;
    localparam logic [FPIX_W-1:0] FRAME_PIXELS_RESET = 20'd307200;

    // Front stage to frame store
    typedef struct packed {
        logic [CH_W-1:0]   gray;
        logic [ADDR_W-1:0] addr;
    } t_pix;

    // Frame store to back stage
    typedef struct packed {
        logic [CH_W-1:0] gray;
        logic [CH_W-1:0] prev;
    } t_res;

endpackage

FILE: src/fda_front.sv
module fda_front
    import fda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [CH_W-1:0]   i_blue,
    input  logic [CH_W-1:0]   i_green,
    input  logic [CH_W-1:0]   i_red,
    input  logic              i_frame_start,
    input  logic [FPIX_W-1:0] i_frame_pixels,
    input  logic              i_busy,
    input  logic              i_adv,
    output logic              o_stall,
    output logic              o_vld,
    output t_pix              o_pix
);

    logic              r_vld;
    t_pix              r_pix;
    logic [ADDR_W-1:0] r_pix_addr;

    logic              w_take;
    logic [SUM_W-1:0]  w_sum;
    logic [PROD_W-1:0] w_prod;
    logic [CH_W-1:0]   w_gray;
    logic [ADDR_W-1:0] w_addr;
    logic [CNT_W-1:0]  w_next;
    logic              w_wrap;

    // Hold off the source while clearing or while this stage cannot move on
    assign o_stall = i_busy || (r_vld && !i_adv);
    assign w_take  = i_valid && !o_stall;

    // Weighted sum, then divide by ten through the reciprocal
    assign w_sum  = SUM_W'(i_blue) + SUM_W'(i_green) * W_GREEN
                  + SUM_W'(i_red) * W_RED + ROUND_BIAS;
    assign w_prod = PROD_W'(w_sum) * RECIP_10;
    assign w_gray = w_prod[GRAY_SHIFT +: CH_W];

    // Pixel position and its successor
    assign w_addr = i_frame_start ? '0 : r_pix_addr;
    assign w_next = CNT_W'(w_addr) + CNT_W'(1);
    assign w_wrap = (w_next >= CNT_W'(i_frame_pixels)) || (w_next >= CNT_W'(FRAME_DEPTH));

    // Advance the address counter on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_pix_addr <= '0;
        end else begin
            if (!r_vld || i_adv) begin
                r_vld <= w_take;
            end
            if (w_take) begin
                r_pix_addr <= w_wrap ? '0 : w_next[ADDR_W-1:0];
            end
        end
    end

    // Capture the pixel payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pix.gray <= w_gray;
            r_pix.addr <= w_addr;
        end
    end

    assign o_vld = r_vld;
    assign o_pix = r_pix;

endmodule

FILE: src/fda_store.sv
module fda_store
    import fda_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s1_vld,
    input  t_pix i_s1_pix,
    input  logic i_adv,
    output logic o_adv,
    output logic o_busy,
    output logic o_vld,
    output t_res o_res
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FRAME_DEPTH - 1);

    logic [CH_W-1:0]   r_mem [FRAME_DEPTH];
    logic [CH_W-1:0]   r_rdata;
    logic [CH_W-1:0]   r_gray;
    logic              r_vld;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              w_mv;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CH_W-1:0]   w_wdata;

    assign o_adv = !r_vld || i_adv;
    assign w_mv  = i_s1_vld && o_adv;

    // Clear pass writes zero, otherwise write the new gray at the pixel position
    assign w_we    = r_clr_busy || w_mv;
    assign w_waddr = r_clr_busy ? r_clr_addr : i_s1_pix.addr;
    assign w_wdata = r_clr_busy ? '0 : i_s1_pix.gray;

    // Step the clearing pass through every entry after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_vld      <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (o_adv) begin
                r_vld <= i_s1_vld;
            end
        end
    end

    // Read the old value and write the new one at the same edge
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_mv) begin
            r_rdata <= r_mem[i_s1_pix.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv) begin
            r_gray <= i_s1_pix.gray;
        end
    end

    assign o_busy     = r_clr_busy;
    assign o_vld      = r_vld;
    assign o_res.gray = r_gray;
    assign o_res.prev = r_rdata;

    // No pixel may reach the store while it is being cleared
    a_no_pix_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_s1_vld)
        else $error("pixel reached frame store during clearing pass");

    // Read data must hold while the stage is stalled
    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !i_adv) |=> $stable(r_rdata))
        else $error("frame store read data changed under stall");

    // Clearing pass visits entries in order
    a_clr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clr_busy && (r_clr_addr != LAST_ADDR))
            |=> (r_clr_busy && (r_clr_addr == $past(r_clr_addr) + ADDR_W'(1))))
        else $error("clearing pass skipped an entry");

endmodule

FILE: src/fda_back.sv
module fda_back
    import fda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  t_res              i_res,
    input  logic [GAIN_W-1:0] i_gain,
    input  logic              i_stall,
    output logic              o_adv,
    output logic              o_valid,
    output logic [CH_W-1:0]   o_gray_value,
    output logic [CH_W-1:0]   o_previous_gray,
    output logic [CH_W-1:0]   o_difference,
    output logic [CH_W-1:0]   o_amplified
);

    localparam int AMP_W = CH_W + GAIN_W;

    logic            r_valid;
    logic [CH_W-1:0] r_gray;
    logic [CH_W-1:0] r_prev;
    logic [CH_W-1:0] r_diff;
    logic [CH_W-1:0] r_amp;

    logic [CH_W-1:0]  w_diff;
    logic [AMP_W-1:0] w_amp;
    logic [CH_W-1:0]  w_sat;
    logic             w_load;

    assign o_adv  = !r_valid || !i_stall;
    assign w_load = i_vld && o_adv;

    // Absolute difference, scale by gain, clip to a byte
    assign w_diff = (i_res.gray >= i_res.prev) ? (i_res.gray - i_res.prev)
                                               : (i_res.prev - i_res.gray);
    assign w_amp  = AMP_W'(w_diff) * AMP_W'(i_gain);
    assign w_sat  = (|w_amp[AMP_W-1:CH_W]) ? SAT_MAX : w_amp[CH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_vld;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_gray <= i_res.gray;
            r_prev <= i_res.prev;
            r_diff <= w_diff;
            r_amp  <= w_sat;
        end
    end

    assign o_valid         = r_valid;
    assign o_gray_value    = r_gray;
    assign o_previous_gray = r_prev;
    assign o_difference    = r_diff;
    assign o_amplified     = r_amp;

endmodule

FILE: src/frame_difference_amplifier.sv
// Frame difference amplifier: takes one BGR pixel per clock when not stalled and
// returns its gray value, the gray stored for the same position in the previous
// frame, their absolute difference and that difference times gain, clipped to 255.
// The frame store does at most one read and one write per cycle, and the result is
// registered in the front, store and back stages. After reset the frame store is
// zeroed in a clearing pass over all 524288 entries, during which o_stall is high;
// configuration writes are taken during that time as always.
module frame_difference_amplifier
    import fda_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CH_W-1:0]       i_blue,
    input  logic [CH_W-1:0]       i_green,
    input  logic [CH_W-1:0]       i_red,
    input  logic                  i_frame_start,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CH_W-1:0]       o_gray_value,
    output logic [CH_W-1:0]       o_previous_gray,
    output logic [CH_W-1:0]       o_difference,
    output logic [CH_W-1:0]       o_amplified
);

    logic [GAIN_W-1:0] r_gain;
    logic [FPIX_W-1:0] r_frame_pixels;

    logic w_busy;
    logic w_s1_vld;
    t_pix w_s1_pix;
    logic w_s2_adv;
    logic w_s2_vld;
    t_res w_s2_res;
    logic w_s3_adv;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain         <= GAIN_RESET;
            r_frame_pixels <= FRAME_PIXELS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN:         r_gain         <= i_cfg_data[GAIN_W-1:0];
                CFG_FRAME_PIXELS: r_frame_pixels <= i_cfg_data[FPIX_W-1:0];
                default: ;
            endcase
        end
    end

    fda_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_blue         (i_blue),
        .i_green        (i_green),
        .i_red          (i_red),
        .i_frame_start  (i_frame_start),
        .i_frame_pixels (r_frame_pixels),
        .i_busy         (w_busy),
        .i_adv          (w_s2_adv),
        .o_stall        (o_stall),
        .o_vld          (w_s1_vld),
        .o_pix          (w_s1_pix)
    );

    fda_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s1_vld (w_s1_vld),
        .i_s1_pix (w_s1_pix),
        .i_adv    (w_s3_adv),
        .o_adv    (w_s2_adv),
        .o_busy   (w_busy),
        .o_vld    (w_s2_vld),
        .o_res    (w_s2_res)
    );

    fda_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (w_s2_vld),
        .i_res           (w_s2_res),
        .i_gain          (r_gain),
        .i_stall         (i_stall),
        .o_adv           (w_s3_adv),
        .o_valid         (o_valid),
        .o_gray_value    (o_gray_value),
        .o_previous_gray (o_previous_gray),
        .o_difference    (o_difference),
        .o_amplified     (o_amplified)
    );

endmodule
